[sv/tcfs_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and helpers of the timed color fade sequencer
package tcfs_pkg;

   // field widths
   localparam int COLOR_BITS     = 8;
   localparam int REG_BITS       = 24;
   localparam int ELAPSED_BITS   = 16;
   localparam int LEVEL_BITS     = 8;
   localparam int PHASE_BITS     = 3;
   localparam int CSR_IDX_BITS   = 3;
   localparam int TIMER_BITS_DEF = 24;

   // channel bookkeeping
   localparam int NUM_CHANS      = 3;
   localparam int CHAN_IDX_BITS  = 2;

   // blend numerator is channel difference times clamped timer
   localparam int NUM_BITS       = COLOR_BITS + REG_BITS;

   // brightness: sum of three channels divided by three via reciprocal
   localparam int SUM_BITS       = COLOR_BITS + 2;
   localparam int DIV3_MUL       = 683;
   localparam int DIV3_SHIFT     = 11;
   localparam int DIV3_BITS      = SUM_BITS + 10;

   // register reset values
   localparam logic [REG_BITS-1:0] DAY_TICKS_RST    = 24'd120000;
   localparam logic [REG_BITS-1:0] NIGHT_TICKS_RST  = 24'd120000;
   localparam logic [REG_BITS-1:0] FADE_TICKS_RST   = 24'd8000;
   localparam logic [REG_BITS-1:0] DAY_COLOR_RST    = 24'd9883627;
   localparam logic [REG_BITS-1:0] SUNSET_COLOR_RST = 24'd15102771;
   localparam logic [REG_BITS-1:0] NIGHT_COLOR_RST  = 24'd855322;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_DAY     = 3'd0,
      PH_SUNSET  = 3'd1,
      PH_DUSK    = 3'd2,
      PH_NIGHT   = 3'd3,
      PH_SUNRISE = 3'd4
   } phase_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DAY_TICKS    = 3'd0,
      CSR_NIGHT_TICKS  = 3'd1,
      CSR_FADE_TICKS   = 3'd2,
      CSR_DAY_COLOR    = 3'd3,
      CSR_SUNSET_COLOR = 3'd4,
      CSR_NIGHT_COLOR  = 3'd5
   } csr_reg_type;

   // colors and duration that belong to the current phase
   typedef struct packed {
      logic [REG_BITS-1:0] from_color;
      logic [REG_BITS-1:0] to_color;
      logic [REG_BITS-1:0] dur;
      phase_type           next_phase;
   } phase_cfg_type;

   // serial divider request and response
   typedef struct packed {
      logic                start;
      logic [NUM_BITS-1:0] num;
      logic [REG_BITS-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [COLOR_BITS-1:0] quo;
   } div_rsp_type;

   // pick one channel out of a packed color, red highest
   function automatic logic [COLOR_BITS-1:0] chan_of(input logic [REG_BITS-1:0] color,
                                                     input logic [CHAN_IDX_BITS-1:0] idx);
      logic [COLOR_BITS-1:0] result;
      case (idx)
         2'd0: result = color[2*COLOR_BITS +: COLOR_BITS];
         2'd1: result = color[COLOR_BITS +: COLOR_BITS];
         default: result = color[0 +: COLOR_BITS];
      endcase
      return result;
   endfunction

endpackage

[sv/tcfs_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces for tick, result and register write transactions

interface tcfs_req_if;
   import tcfs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ELAPSED_BITS-1:0] elapsed;
   modport source (output valid, output elapsed, input ready);
   modport sink (input valid, input elapsed, output ready);
endinterface

interface tcfs_rsp_if;
   import tcfs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COLOR_BITS-1:0] red;
   logic [COLOR_BITS-1:0] green;
   logic [COLOR_BITS-1:0] blue;
   logic [LEVEL_BITS-1:0] brightness;
   logic [PHASE_BITS-1:0] phase;
   modport source (output valid, output red, output green, output blue,
                   output brightness, output phase, input ready);
   modport sink (input valid, input red, input green, input blue,
                 input brightness, input phase, output ready);
endinterface

interface tcfs_csr_if;
   import tcfs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [REG_BITS-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[sv/timed_color_fade_sequencer.sv]
`timescale 1ns / 1ps
// A tick transaction is accepted only in idle, and no new tick is taken until its result
// is loaded into the output register; zero-duration phases skip the divide, otherwise the
// 8-step bit-serial divider runs once per color channel.
// A finished result waits in the output register while the next tick is accepted.
// Reset (synchronous): day phase, phase timer zero, registers to their default values.
module timed_color_fade_sequencer #(
   parameter int TIMER_BITS = tcfs_pkg::TIMER_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   tcfs_req_if.sink    req_bus,
   tcfs_rsp_if.source  rsp_bus,
   tcfs_csr_if.sink    csr_bus
);
   import tcfs_pkg::*;

   localparam int CMP_BITS = (TIMER_BITS > REG_BITS) ? TIMER_BITS : REG_BITS;
   localparam logic [CHAN_IDX_BITS-1:0] LAST_CHAN = CHAN_IDX_BITS'(NUM_CHANS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_MUL,
      S_DIV,
      S_OUT
   } state_type;

   state_type                  state_ff, state_in;
   phase_type                  phase_ff, phase_in;
   phase_type                  shown_ff, shown_in;
   logic [TIMER_BITS-1:0]      timer_ff, timer_in;
   logic [REG_BITS-1:0]        t_ff, t_in;
   logic [REG_BITS-1:0]        dur_ff, dur_in;
   logic [REG_BITS-1:0]        from_ff, from_in;
   logic [REG_BITS-1:0]        to_ff, to_in;
   logic [CHAN_IDX_BITS-1:0]   ch_ff, ch_in;
   logic [COLOR_BITS-1:0]      res_ff [NUM_CHANS];
   logic [COLOR_BITS-1:0]      res_in [NUM_CHANS];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COLOR_BITS-1:0]      red_ff, red_in;
   logic [COLOR_BITS-1:0]      green_ff, green_in;
   logic [COLOR_BITS-1:0]      blue_ff, blue_in;
   logic [LEVEL_BITS-1:0]      bright_ff, bright_in;
   logic [PHASE_BITS-1:0]      rsp_phase_ff, rsp_phase_in;

   phase_cfg_type              phase_cfg;
   div_req_type                div_req;
   div_rsp_type                div_rsp;

   logic                       accept;
   logic [TIMER_BITS:0]        timer_sum;
   logic [CMP_BITS-1:0]        timer_ext;
   logic [CMP_BITS-1:0]        dur_ext;
   logic                       timer_lt_dur;
   logic [COLOR_BITS-1:0]      a_chan;
   logic [COLOR_BITS-1:0]      b_chan;
   logic                       falling;
   logic [COLOR_BITS-1:0]      diff_mag;
   logic [NUM_BITS-1:0]        product;
   logic [COLOR_BITS-1:0]      blend;
   logic [SUM_BITS-1:0]        chan_sum;
   logic [DIV3_BITS-1:0]       bright_prod;

   tcfs_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_bus   (csr_bus),
      .phase     (phase_ff),
      .phase_cfg (phase_cfg)
   );

   tcfs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // handshake
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // saturating timer add and end-of-phase compare
   assign timer_sum    = {1'b0, timer_ff} + (TIMER_BITS + 1)'(req_bus.elapsed);
   assign timer_ext    = CMP_BITS'(timer_ff);
   assign dur_ext      = CMP_BITS'(phase_cfg.dur);
   assign timer_lt_dur = (timer_ext < dur_ext);

   // current channel: magnitude of the difference times the clamped timer
   assign a_chan   = chan_of(from_ff, ch_ff);
   assign b_chan   = chan_of(to_ff, ch_ff);
   assign falling  = (a_chan > b_chan);
   assign diff_mag = falling ? (a_chan - b_chan) : (b_chan - a_chan);
   assign product  = NUM_BITS'(diff_mag) * NUM_BITS'(t_ff);

   // truncation toward zero: apply the sign to the unsigned quotient
   assign blend = falling ? (a_chan - div_rsp.quo) : (a_chan + div_rsp.quo);

   // brightness as sum times reciprocal of three
   assign chan_sum    = SUM_BITS'(res_ff[0]) + SUM_BITS'(res_ff[1]) + SUM_BITS'(res_ff[2]);
   assign bright_prod = DIV3_BITS'(chan_sum) * DIV3_BITS'(DIV3_MUL);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      shown_in     = shown_ff;
      timer_in     = timer_ff;
      t_in         = t_ff;
      dur_in       = dur_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      ch_in        = ch_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      bright_in    = bright_ff;
      rsp_phase_in = rsp_phase_ff;
      div_req.start = 1'b0;
      div_req.num   = product;
      div_req.den   = dur_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               timer_in = timer_sum[TIMER_BITS] ? '1 : timer_sum[TIMER_BITS-1:0];
               state_in = S_LOAD;
            end
         end
         // capture phase data, then advance the phase if its time is up
         S_LOAD: begin
            from_in  = phase_cfg.from_color;
            to_in    = phase_cfg.to_color;
            dur_in   = phase_cfg.dur;
            t_in     = timer_lt_dur ? timer_ext[REG_BITS-1:0] : phase_cfg.dur;
            shown_in = phase_ff;
            ch_in    = '0;
            if (!timer_lt_dur) begin
               timer_in = '0;
               phase_in = phase_cfg.next_phase;
            end
            state_in = S_MUL;
         end
         // zero duration shows the end color without a divide
         S_MUL: begin
            if (dur_ff == '0) begin
               res_in[0] = res_ff[1];
               res_in[1] = res_ff[2];
               res_in[2] = b_chan;
               if (ch_ff == LAST_CHAN) begin
                  state_in = S_OUT;
               end else begin
                  ch_in = ch_ff + 1'b1;
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               res_in[0] = res_ff[1];
               res_in[1] = res_ff[2];
               res_in[2] = blend;
               if (ch_ff == LAST_CHAN) begin
                  state_in = S_OUT;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         // load the output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               red_in       = res_ff[0];
               green_in     = res_ff[1];
               blue_in      = res_ff[2];
               bright_in    = bright_prod[DIV3_SHIFT +: LEVEL_BITS];
               rsp_phase_in = shown_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_DAY;
         timer_ff     <= '0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shown_ff     <= shown_in;
      t_ff         <= t_in;
      dur_ff       <= dur_in;
      from_ff      <= from_in;
      to_ff        <= to_in;
      res_ff       <= res_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      bright_ff    <= bright_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.red        = red_ff;
   assign rsp_bus.green      = green_ff;
   assign rsp_bus.blue       = blue_ff;
   assign rsp_bus.brightness = bright_ff;
   assign rsp_bus.phase      = rsp_phase_ff;

   // phase only moves on right after the load step
   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (phase_ff != $past(phase_ff))) |-> $past(state_ff == S_LOAD))
      else $error("phase changed outside the load step");

   // a result only appears from the output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output step");

   // divider completion is only seen while waiting for it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished while not waited for");

endmodule

[sv/tcfs_regs.sv]
`timescale 1ns / 1ps
// configuration registers and per-phase color and duration selection
module tcfs_regs (
   input  logic                    clock,
   input  logic                    reset,
   tcfs_csr_if.sink                csr_bus,
   input  tcfs_pkg::phase_type     phase,
   output tcfs_pkg::phase_cfg_type phase_cfg
);
   import tcfs_pkg::*;

   logic [REG_BITS-1:0] day_ticks_ff;
   logic [REG_BITS-1:0] night_ticks_ff;
   logic [REG_BITS-1:0] fade_ticks_ff;
   logic [REG_BITS-1:0] day_color_ff;
   logic [REG_BITS-1:0] sunset_color_ff;
   logic [REG_BITS-1:0] night_color_ff;

   // writes are always accepted
   assign csr_bus.ready = 1'b1;

   // register file, out-of-range indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         day_ticks_ff    <= DAY_TICKS_RST;
         night_ticks_ff  <= NIGHT_TICKS_RST;
         fade_ticks_ff   <= FADE_TICKS_RST;
         day_color_ff    <= DAY_COLOR_RST;
         sunset_color_ff <= SUNSET_COLOR_RST;
         night_color_ff  <= NIGHT_COLOR_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_DAY_TICKS:    day_ticks_ff    <= csr_bus.data;
            CSR_NIGHT_TICKS:  night_ticks_ff  <= csr_bus.data;
            CSR_FADE_TICKS:   fade_ticks_ff   <= csr_bus.data;
            CSR_DAY_COLOR:    day_color_ff    <= csr_bus.data;
            CSR_SUNSET_COLOR: sunset_color_ff <= csr_bus.data;
            CSR_NIGHT_COLOR:  night_color_ff  <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // endpoints and duration of the current phase; hold phases blend a color with itself
   always_comb begin
      case (phase)
         PH_SUNSET: begin
            phase_cfg.from_color = day_color_ff;
            phase_cfg.to_color   = sunset_color_ff;
            phase_cfg.dur        = fade_ticks_ff;
            phase_cfg.next_phase = PH_DUSK;
         end
         PH_DUSK: begin
            phase_cfg.from_color = sunset_color_ff;
            phase_cfg.to_color   = night_color_ff;
            phase_cfg.dur        = fade_ticks_ff;
            phase_cfg.next_phase = PH_NIGHT;
         end
         PH_NIGHT: begin
            phase_cfg.from_color = night_color_ff;
            phase_cfg.to_color   = night_color_ff;
            phase_cfg.dur        = night_ticks_ff;
            phase_cfg.next_phase = PH_SUNRISE;
         end
         PH_SUNRISE: begin
            phase_cfg.from_color = night_color_ff;
            phase_cfg.to_color   = day_color_ff;
            phase_cfg.dur        = fade_ticks_ff;
            phase_cfg.next_phase = PH_DAY;
         end
         default: begin
            phase_cfg.from_color = day_color_ff;
            phase_cfg.to_color   = day_color_ff;
            phase_cfg.dur        = day_ticks_ff;
            phase_cfg.next_phase = PH_SUNSET;
         end
      endcase
   end

endmodule

[sv/tcfs_div.sv]
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
module tcfs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tcfs_pkg::div_req_type div_req,
   output tcfs_pkg::div_rsp_type div_rsp
);
   import tcfs_pkg::*;

   localparam int CNT_BITS = $clog2(COLOR_BITS + 1);

   logic [REG_BITS-1:0]   rem_ff, rem_in;
   logic [REG_BITS-1:0]   den_ff, den_in;
   logic [COLOR_BITS-1:0] low_ff, low_in;
   logic [COLOR_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [REG_BITS:0]     trial;
   logic                  take;

   // quotient is known to fit in one channel, so the upper numerator bits
   // start out as the partial remainder and the low bits shift in one a cycle
   always_comb begin
      trial   = {rem_ff, low_ff[COLOR_BITS-1]};
      take    = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = div_req.num[NUM_BITS-1 -: REG_BITS];
         low_in = div_req.num[COLOR_BITS-1:0];
         den_in = div_req.den;
         quo_in = '0;
         cnt_in = CNT_BITS'(COLOR_BITS);
      end else if (cnt_ff != '0) begin
         rem_in  = take ? REG_BITS'(trial - {1'b0, den_ff}) : trial[REG_BITS-1:0];
         low_in  = {low_ff[COLOR_BITS-2:0], 1'b0};
         quo_in  = {quo_ff[COLOR_BITS-2:0], take};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

   // a new division only starts on an idle unit
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (cnt_ff == '0))
      else $error("divider started while busy");

   // divisor is never zero
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (div_req.den != '0))
      else $error("divider started with zero divisor");

   // final remainder is below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < den_ff))
      else $error("divider remainder out of range");

endmodule
